@@ hdl/ucc_pkg.sv @@
// Package for the upwind convection coefficient unit.
// Types, scheme and register codes, and the round/saturate function.
// No dependencies.
package ucc_pkg;

  localparam int DATA_W   = 32;
  localparam int TRANS_W  = 31;
  localparam int ACC_W    = 40;   // sums in 1/8 LSB units
  localparam int FRAC_SH  = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [TRANS_W-1:0] TRANS_RESET = 31'd16777216;

  typedef enum logic [1:0] {
    SCH_FOU   = 2'd0,
    SCH_SOU   = 2'd1,
    SCH_QUAD  = 2'd2
  } scheme_t;

  // register index, taken from paddr[2]
  localparam logic REG_SCHEME    = 1'b0;
  localparam logic REG_TRANSIENT = 1'b1;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [DATA_W-1:0] coef_t;

  typedef struct packed {
    acc_t t_u;     // flux * upwind weight
    acc_t t_d;     // flux * downwind weight
    acc_t t_uu;    // flux * far-upwind weight
    acc_t t_edge;  // flux * 1.0 (boundary term)
    logic neg;
    logic edge_f;
  } face_terms_t;

  typedef struct packed {
    coef_t west;
    coef_t east;
    coef_t south;
    coef_t north;
    coef_t far_west;
    coef_t far_east;
    coef_t far_south;
    coef_t far_north;
    coef_t centre;
  } coef_set_t;

  localparam acc_t Q_MAX = acc_t'(64'sh0000_0000_7FFF_FFFF);
  localparam acc_t Q_MIN = acc_t'(-64'sh0000_0000_8000_0000);

  // round to nearest (ties up), drop the 3 fraction bits, saturate to 32 bits
  function automatic coef_t round_sat(input acc_t a);
    acc_t v;
    acc_t q;
    coef_t r;
    v = a + acc_t'(4);
    q = v >>> FRAC_SH;
    if (q > Q_MAX) begin
      r = coef_t'(Q_MAX);
    end else if (q < Q_MIN) begin
      r = coef_t'(Q_MIN);
    end else begin
      r = q[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/upwind_convection_coefficients_unit.sv @@
// Top level of the upwind convection coefficient unit (FOU / SOU / QUICK).
// Input register, face terms, assembly, result register. Depends on ucc_pkg,
// ucc_cfg_regs, ucc_face_terms, ucc_assemble.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in_     | in_valid / in_ready  | flux and edge flag of each face (E, W, N, S)
//   out_    | out_valid / out_ready| nine Q8.24 coefficients
//   cfg_    | APB psel/penable     | scheme select, transient term
//
// An accepted input passes the input register, then the result register; one cell per cycle while out_ready holds.
// The rate is set by the two-stage register pipeline: the adder trees of the
// assembly sit between the input register and the result register.
// Reset (rst_n, synchronous) empties both stages and restores the registers.
// A stalled output holds its result; the input stage still takes a transaction
// while it is empty, so in_ready drops only when both stages are full.
module upwind_convection_coefficients_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ucc_pkg::DATA_W-1:0] in_flux_east,
  input  logic signed [ucc_pkg::DATA_W-1:0] in_flux_west,
  input  logic signed [ucc_pkg::DATA_W-1:0] in_flux_north,
  input  logic signed [ucc_pkg::DATA_W-1:0] in_flux_south,
  input  logic                              in_at_east_edge,
  input  logic                              in_at_west_edge,
  input  logic                              in_at_north_edge,
  input  logic                              in_at_south_edge,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_west,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_east,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_south,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_north,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_far_west,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_far_east,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_far_south,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_far_north,
  output logic signed [ucc_pkg::DATA_W-1:0] out_coef_centre,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ucc_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [ucc_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [ucc_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import ucc_pkg::*;

  logic [1:0]         scheme;
  logic [TRANS_W-1:0] transient;

  logic               s1_valid_r;
  coef_t              fe_r, fw_r, fn_r, fs_r;
  logic               ee_r, we_r, ne_r, se_r;
  logic               out_valid_r;
  coef_set_t          coef_r;
  coef_set_t          coef_nxt;

  logic               out_adv;
  logic               s1_adv;
  logic               in_take;

  face_terms_t        te, tw, tn, ts;

  ucc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .scheme      (scheme),
    .transient   (transient)
  );

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_take  = in_valid && in_ready;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      fe_r <= in_flux_east;
      fw_r <= in_flux_west;
      fn_r <= in_flux_north;
      fs_r <= in_flux_south;
      ee_r <= in_at_east_edge;
      we_r <= in_at_west_edge;
      ne_r <= in_at_north_edge;
      se_r <= in_at_south_edge;
    end
  end

  ucc_face_terms u_face_e (.flux(fe_r), .at_edge(ee_r), .scheme(scheme), .terms(te));
  ucc_face_terms u_face_w (.flux(fw_r), .at_edge(we_r), .scheme(scheme), .terms(tw));
  ucc_face_terms u_face_n (.flux(fn_r), .at_edge(ne_r), .scheme(scheme), .terms(tn));
  ucc_face_terms u_face_s (.flux(fs_r), .at_edge(se_r), .scheme(scheme), .terms(ts));

  ucc_assemble u_asm (
    .te        (te),
    .tw        (tw),
    .tn        (tn),
    .ts        (ts),
    .transient (transient),
    .coef      (coef_nxt)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      coef_r <= coef_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coef_west      = coef_r.west;
  assign out_coef_east      = coef_r.east;
  assign out_coef_south     = coef_r.south;
  assign out_coef_north     = coef_r.north;
  assign out_coef_far_west  = coef_r.far_west;
  assign out_coef_far_east  = coef_r.far_east;
  assign out_coef_far_south = coef_r.far_south;
  assign out_coef_far_north = coef_r.far_north;
  assign out_coef_centre    = coef_r.centre;

endmodule

@@ hdl/ucc_cfg_regs.sv @@
// Configuration registers of the coefficient unit: scheme select and transient term.
// APB-style write/read port. Depends on ucc_pkg.
module ucc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ucc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [ucc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [ucc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  output logic [1:0]                    scheme,
  output logic [ucc_pkg::TRANS_W-1:0]   transient
);
  import ucc_pkg::*;

  logic [1:0]         scheme_r;
  logic [TRANS_W-1:0] transient_r;
  logic               wr_en;
  logic               reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r    <= 2'd0;
      transient_r <= TRANS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCHEME:    scheme_r    <= cfg_pwdata[1:0];
        REG_TRANSIENT: transient_r <= cfg_pwdata[TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCHEME:    cfg_prdata = {{(CFG_DW-2){1'b0}}, scheme_r};
      REG_TRANSIENT: cfg_prdata = {{(CFG_DW-TRANS_W){1'b0}}, transient_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign scheme    = scheme_r;
  assign transient = transient_r;

endmodule

@@ hdl/ucc_face_terms.sv @@
// Weighted flux terms of one cell face for the selected upwind scheme.
// Shift-and-add weights in 1/8 LSB units. Depends on ucc_pkg.
module ucc_face_terms (
  input  logic signed [ucc_pkg::DATA_W-1:0] flux,
  input  logic                              at_edge,
  input  logic [1:0]                        scheme,
  output ucc_pkg::face_terms_t              terms
);
  import ucc_pkg::*;

  acc_t f1, f2, f4, f8;

  assign f1 = {{(ACC_W-DATA_W){flux[DATA_W-1]}}, flux};
  assign f2 = f1 <<< 1;
  assign f4 = f1 <<< 2;
  assign f8 = f1 <<< 3;

  always_comb begin
    terms.t_edge = f8;
    terms.neg    = flux[DATA_W-1];
    terms.edge_f = at_edge;
    unique case (scheme_t'(scheme))
      SCH_SOU: begin           // 1.5, 0, -0.5
        terms.t_u  = f8 + f4;
        terms.t_d  = '0;
        terms.t_uu = -f4;
      end
      SCH_QUAD: begin          // 0.75, 0.375, -0.125
        terms.t_u  = f4 + f2;
        terms.t_d  = f2 + f1;
        terms.t_uu = -f1;
      end
      default: begin           // first-order upwind, also unused code
        terms.t_u  = f8;
        terms.t_d  = '0;
        terms.t_uu = '0;
      end
    endcase
  end

endmodule

@@ hdl/ucc_assemble.sv @@
// Sums the face terms into the nine coefficients, then rounds and saturates.
// Combinational. Depends on ucc_pkg.
module ucc_assemble (
  input  ucc_pkg::face_terms_t              te,
  input  ucc_pkg::face_terms_t              tw,
  input  ucc_pkg::face_terms_t              tn,
  input  ucc_pkg::face_terms_t              ts,
  input  logic [ucc_pkg::TRANS_W-1:0]       transient,
  output ucc_pkg::coef_set_t                coef
);
  import ucc_pkg::*;

  acc_t aw, ae, as_, an, aww, aee, ass, ann, ap;

  always_comb begin
    aw  = '0;
    ae  = '0;
    as_ = '0;
    an  = '0;
    aww = '0;
    aee = '0;
    ass = '0;
    ann = '0;
    ap  = acc_t'({{(ACC_W-TRANS_W-FRAC_SH){1'b0}}, transient, {FRAC_SH{1'b0}}});

    // east face
    if (te.edge_f) begin
      ae = ae - te.t_edge;
    end else if (!te.neg) begin
      ap = ap + te.t_u;
      ae = ae - te.t_d;
      aw = aw - te.t_uu;
    end else begin
      ae  = ae - te.t_u;
      ap  = ap + te.t_d;
      aee = aee - te.t_uu;
    end

    // west face
    if (tw.edge_f) begin
      aw = aw + tw.t_edge;
    end else if (!tw.neg) begin
      aw  = aw + tw.t_u;
      ap  = ap - tw.t_d;
      aww = aww + tw.t_uu;
    end else begin
      ap = ap - tw.t_u;
      aw = aw + tw.t_d;
      ae = ae + tw.t_uu;
    end

    // north face
    if (tn.edge_f) begin
      an = an - tn.t_edge;
    end else if (!tn.neg) begin
      ap  = ap + tn.t_u;
      an  = an - tn.t_d;
      as_ = as_ - tn.t_uu;
    end else begin
      an  = an - tn.t_u;
      ap  = ap + tn.t_d;
      ann = ann - tn.t_uu;
    end

    // south face
    if (ts.edge_f) begin
      as_ = as_ + ts.t_edge;
    end else if (!ts.neg) begin
      as_ = as_ + ts.t_u;
      ap  = ap - ts.t_d;
      ass = ass + ts.t_uu;
    end else begin
      ap  = ap - ts.t_u;
      as_ = as_ + ts.t_d;
      an  = an + ts.t_uu;
    end

    coef.west      = round_sat(aw);
    coef.east      = round_sat(ae);
    coef.south     = round_sat(as_);
    coef.north     = round_sat(an);
    coef.far_west  = round_sat(aww);
    coef.far_east  = round_sat(aee);
    coef.far_south = round_sat(ass);
    coef.far_north = round_sat(ann);
    coef.centre    = round_sat(ap);
  end

endmodule

@@ sim/upwind_convection_coefficients_unit_tb.sv @@
// Testbench for upwind_convection_coefficients_unit: drives cells and APB writes,
// predicts the nine Q8.24 coefficients per cell and checks every transaction.
// Depends on ucc_pkg and the RTL of the unit.
module upwind_convection_coefficients_unit_tb;
  import ucc_pkg::*;

  localparam logic [1:0] SCH_SPARE = 2'd3;   // unused code, behaves as first-order upwind
  localparam int HOLD_CYCLES = 60;
  localparam int RAND_PHASES = 6;
  localparam int CELLS_PER_PHASE = 270;

  typedef struct packed {
    logic signed [DATA_W-1:0] flux_east;
    logic signed [DATA_W-1:0] flux_west;
    logic signed [DATA_W-1:0] flux_north;
    logic signed [DATA_W-1:0] flux_south;
    logic                     at_east_edge;
    logic                     at_west_edge;
    logic                     at_north_edge;
    logic                     at_south_edge;
  } cell_t;

  class coef_ledger;
    logic [1:0]         scheme_code;
    logic [TRANS_W-1:0] transient;
    coef_set_t          pending_coefs[$];
    int                 mismatches;

    function new();
      scheme_code = SCH_FOU;
      transient   = TRANS_RESET;
      mismatches  = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_DW-1:0] value);
      if (idx == REG_SCHEME) begin
        scheme_code = value[1:0];
      end else begin
        transient = value[TRANS_W-1:0];
      end
    endfunction

    // exact sum in 1/8 LSB, round half up, saturate to 32 bits
    function coef_t to_q824(longint acc8);
      longint q;
      q = (acc8 + 64'sd4) >>> 3;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[DATA_W-1:0];
    endfunction

    function coef_set_t assemble_coefs(cell_t c);
      longint wu, wd, wuu;
      longint fe, fw, fn, fs;
      longint acc_w, acc_e, acc_s, acc_n;
      longint acc_ww, acc_ee, acc_ss, acc_nn, acc_p;
      coef_set_t r;
      case (scheme_code)
        SCH_SOU: begin
          wu = 12; wd = 0; wuu = -4;
        end
        SCH_QUAD: begin
          wu = 6; wd = 3; wuu = -1;
        end
        default: begin
          wu = 8; wd = 0; wuu = 0;
        end
      endcase
      fe = longint'(c.flux_east);
      fw = longint'(c.flux_west);
      fn = longint'(c.flux_north);
      fs = longint'(c.flux_south);
      acc_w = 0; acc_e = 0; acc_s = 0; acc_n = 0;
      acc_ww = 0; acc_ee = 0; acc_ss = 0; acc_nn = 0;
      acc_p = longint'(transient) * 8;

      if (c.at_east_edge) begin
        acc_e -= fe * 8;
      end else if (fe >= 0) begin
        acc_p += fe * wu; acc_e -= fe * wd; acc_w -= fe * wuu;
      end else begin
        acc_e -= fe * wu; acc_p += fe * wd; acc_ee -= fe * wuu;
      end

      if (c.at_west_edge) begin
        acc_w += fw * 8;
      end else if (fw >= 0) begin
        acc_w += fw * wu; acc_p -= fw * wd; acc_ww += fw * wuu;
      end else begin
        acc_p -= fw * wu; acc_w += fw * wd; acc_e += fw * wuu;
      end

      if (c.at_north_edge) begin
        acc_n -= fn * 8;
      end else if (fn >= 0) begin
        acc_p += fn * wu; acc_n -= fn * wd; acc_s -= fn * wuu;
      end else begin
        acc_n -= fn * wu; acc_p += fn * wd; acc_nn -= fn * wuu;
      end

      if (c.at_south_edge) begin
        acc_s += fs * 8;
      end else if (fs >= 0) begin
        acc_s += fs * wu; acc_p -= fs * wd; acc_ss += fs * wuu;
      end else begin
        acc_p -= fs * wu; acc_s += fs * wd; acc_n += fs * wuu;
      end

      r.west      = to_q824(acc_w);
      r.east      = to_q824(acc_e);
      r.south     = to_q824(acc_s);
      r.north     = to_q824(acc_n);
      r.far_west  = to_q824(acc_ww);
      r.far_east  = to_q824(acc_ee);
      r.far_south = to_q824(acc_ss);
      r.far_north = to_q824(acc_nn);
      r.centre    = to_q824(acc_p);
      return r;
    endfunction

    function void note_cell(cell_t c);
      pending_coefs.push_back(assemble_coefs(c));
    endfunction

    function void check_field(string fname, coef_t want, coef_t got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %0d (%h) got %0d (%h)",
                   fname, want, want, got, got);
      end
    endfunction

    function void check_coefs(coef_set_t got);
      coef_set_t want;
      if (pending_coefs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transaction with no cell pending");
        return;
      end
      want = pending_coefs.pop_front();
      check_field("coef_west", want.west, got.west);
      check_field("coef_east", want.east, got.east);
      check_field("coef_south", want.south, got.south);
      check_field("coef_north", want.north, got.north);
      check_field("coef_far_west", want.far_west, got.far_west);
      check_field("coef_far_east", want.far_east, got.far_east);
      check_field("coef_far_south", want.far_south, got.far_south);
      check_field("coef_far_north", want.far_north, got.far_north);
      check_field("coef_centre", want.centre, got.centre);
    endfunction

    function void flush_leftover();
      if (pending_coefs.size() != 0) begin
        mismatches++;
        $display("%0d expected results never arrived", pending_coefs.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [DATA_W-1:0] in_flux_east, in_flux_west, in_flux_north, in_flux_south;
  logic in_at_east_edge, in_at_west_edge, in_at_north_edge, in_at_south_edge;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_W-1:0] out_coef_west, out_coef_east, out_coef_south, out_coef_north;
  logic signed [DATA_W-1:0] out_coef_far_west, out_coef_far_east;
  logic signed [DATA_W-1:0] out_coef_far_south, out_coef_far_north, out_coef_centre;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  coef_ledger ledger;
  bit hold_request;

  upwind_convection_coefficients_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_flux_east(in_flux_east), .in_flux_west(in_flux_west),
    .in_flux_north(in_flux_north), .in_flux_south(in_flux_south),
    .in_at_east_edge(in_at_east_edge), .in_at_west_edge(in_at_west_edge),
    .in_at_north_edge(in_at_north_edge), .in_at_south_edge(in_at_south_edge),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_coef_west(out_coef_west), .out_coef_east(out_coef_east),
    .out_coef_south(out_coef_south), .out_coef_north(out_coef_north),
    .out_coef_far_west(out_coef_far_west), .out_coef_far_east(out_coef_far_east),
    .out_coef_far_south(out_coef_far_south), .out_coef_far_north(out_coef_far_north),
    .out_coef_centre(out_coef_centre),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        ledger.note_cell({in_flux_east, in_flux_west, in_flux_north, in_flux_south,
                          in_at_east_edge, in_at_west_edge, in_at_north_edge,
                          in_at_south_edge});
      if (out_valid && out_ready)
        ledger.check_coefs({out_coef_west, out_coef_east, out_coef_south, out_coef_north,
                            out_coef_far_west, out_coef_far_east, out_coef_far_south,
                            out_coef_far_north, out_coef_centre});
    end
  end

  // receiver: stretches of always-ready, coin-flip and mostly-stalled, plus a held stall on request
  initial begin
    int mode;
    int len;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(5, 80);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      if (hold_request) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
    end
  end

  task automatic send_cell(input cell_t c);
    in_valid         <= 1'b1;
    in_flux_east     <= c.flux_east;
    in_flux_west     <= c.flux_west;
    in_flux_north    <= c.flux_north;
    in_flux_south    <= c.flux_south;
    in_at_east_edge  <= c.at_east_edge;
    in_at_west_edge  <= c.at_west_edge;
    in_at_north_edge <= c.at_north_edge;
    in_at_south_edge <= c.at_south_edge;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_run(input cell_t cells[$]);
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    foreach (cells[i]) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      send_cell(cells[i]);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    ledger.set_reg(idx, value);
  endtask

  task automatic configure(input logic [1:0] code, input logic [CFG_DW-1:0] trans_word);
    write_reg(REG_SCHEME, ($urandom() & ~32'h3) | 32'(code));
    write_reg(REG_TRANSIENT, trans_word);
  endtask

  task automatic drain();
    while (ledger.pending_coefs.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_flux();
    logic signed [DATA_W-1:0] f;
    case ($urandom_range(0, 9))
      0: f = 32'sh8000_0000;
      1: f = 32'sh7FFF_FFFF;
      2: f = '0;
      3: f = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      4, 5: f = $signed($urandom_range(0, 4096)) - 32'sd2048;
      6: f = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $signed($urandom_range(0, 255))
                                  : 32'sh8000_0000 + $signed($urandom_range(0, 255));
      default: f = $urandom();
    endcase
    return f;
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    c.flux_east     = rand_flux();
    c.flux_west     = rand_flux();
    c.flux_north    = rand_flux();
    c.flux_south    = rand_flux();
    c.at_east_edge  = ($urandom_range(0, 3) == 0);
    c.at_west_edge  = ($urandom_range(0, 3) == 0);
    c.at_north_edge = ($urandom_range(0, 3) == 0);
    c.at_south_edge = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  initial begin
    cell_t directed[$];
    cell_t cells[$];
    logic [1:0] code;
    logic [CFG_DW-1:0] trans_word;
    ledger = new();
    hold_request     = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_flux_east     = '0;
    in_flux_west     = '0;
    in_flux_north    = '0;
    in_flux_south    = '0;
    in_at_east_edge  = 1'b0;
    in_at_west_edge  = 1'b0;
    in_at_north_edge = 1'b0;
    in_at_south_edge = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, saturation both ways, all edge faces, small ties, sign mixes, bit patterns
    directed.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'b0000});
    directed.push_back({32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        4'b0000});
    directed.push_back({32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        4'b0000});
    directed.push_back({32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                        4'b1111});
    directed.push_back({-32'sd1, 32'sd1, -32'sd1, 32'sd1, 4'b0000});
    directed.push_back({32'sd1, -32'sd1, 32'sd1, -32'sd1, 4'b0000});
    directed.push_back({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        4'b0000});
    directed.push_back({32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                        4'b1010});

    send_run(directed);
    drain();
    configure(SCH_SOU, 32'h7FFF_FFFF);
    send_run(directed);
    drain();
    configure(SCH_QUAD, 32'h0000_0000);
    send_run(directed);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin code = SCH_QUAD;  trans_word = $urandom(); end
        1: begin code = SCH_SPARE; trans_word = 32'hFFFF_FFFF; end
        2: begin code = SCH_SOU;   trans_word = $urandom(); end
        3: begin code = SCH_FOU;   trans_word = $urandom_range(0, 32'h0100_0000); end
        4: begin code = SCH_QUAD;  trans_word = $urandom_range(0, 255); end
        default: begin code = $urandom_range(0, 3); trans_word = $urandom(); end
      endcase
      configure(code, trans_word);
      if (p == 1 || p == 4) hold_request = 1'b1;
      cells.delete();
      repeat (CELLS_PER_PHASE) cells.push_back(random_cell());
      send_run(cells);
      drain();
    end

    repeat (10) @(posedge clk);
    ledger.flush_leftover();
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
